// File: rtl/core/coc_pkg.sv
// Shared widths, codes and types for the circle obstacle clearance block.
package coc_pkg;

   localparam int COORD_W         = 24;
   localparam int RAD_W           = 23;
   localparam int ABS_W           = 24;
   localparam int SQ_W            = 2 * ABS_W;
   localparam int SUM_W           = 2 * (ABS_W + 1);
   localparam int ROOT_W          = SUM_W / 2;
   localparam int CLR_W           = 27;
   localparam int OBS_IDX_W       = 5;
   localparam int CSR_IDX_W       = 2;
   localparam int DEF_MAX_OBSTACLES = 32;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_BOUND = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_X = 2'd0,
      CSR_MAX_X = 2'd1,
      CSR_MIN_Y = 2'd2,
      CSR_MAX_Y = 2'd3
   } csr_idx_type;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;
   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [RAD_W-1:0]          r;
   } obst_type;

endpackage

// File: rtl/core/coc_isqrt.sv
// Iterative floor square root, one result bit per cycle.
module coc_isqrt
   import coc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  value,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int STEP_W = $clog2(ROOT_W + 1);

   logic [SUM_W-1:0]  val_ff,  val_in;
   logic [ROOT_W+1:0] rem_ff,  rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ROOT_W+1:0] shifted;
   logic [ROOT_W+1:0] trial;

   // Bring down two bits and try the next root bit
   always_comb begin
      shifted = {rem_ff[ROOT_W-1:0], val_ff[SUM_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
         step_in = STEP_W'(ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = {val_ff[SUM_W-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = shifted - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: rtl/core/circle_obstacle_clearance_top.sv
// Top level: obstacle table, sequencer and shared squaring unit.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | op, center_x, center_y, circle_radius
//  rsp     | out       | rsp_valid/rsp_stall | kind, status, obstacle_index, clearance, ...
//  csr     | in        | csr_we              | csr_index, csr_wdata
//
// An add or an empty query goes from the accept step straight to output delivery. A
// query runs, for each stored obstacle in turn: read, two squarings on one multiplier
// (the sum formed with the second), root start, the bit-serial square root, emit; the
// square root is the longest step. Synchronous reset empties the table and restores
// the world bounds. A stalled result holds the sequencer in its emit step.
module circle_obstacle_clearance_top
   import coc_pkg::*;
#(
   parameter int MAX_OBSTACLES = DEF_MAX_OBSTACLES
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_op,
   input  logic signed [COORD_W-1:0]  req_center_x,
   input  logic signed [COORD_W-1:0]  req_center_y,
   input  logic [RAD_W-1:0]           req_circle_radius,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_kind,
   output logic [1:0]                 rsp_status,
   output logic [OBS_IDX_W-1:0]       rsp_obstacle_index,
   output logic signed [CLR_W-1:0]    rsp_clearance,
   output logic                       rsp_intersects,
   output logic                       rsp_any_hit,
   output logic                       rsp_last,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [COORD_W-1:0]         csr_wdata
);

   localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
   localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_READ  = 7'b0000010,
      S_SQX   = 7'b0000100,
      S_SQY   = 7'b0001000,
      S_START = 7'b0010000,
      S_ROOT  = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [COORD_W-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic                      kind_ff, kind_in;
   status_type                status_ff, status_in;
   logic                      any_ff, any_in;
   logic signed [COORD_W-1:0] qx_ff, qy_ff;
   logic [RAD_W-1:0]          qr_ff;
   logic [SQ_W-1:0]           sq_ff;
   logic [SUM_W-1:0]          sum_ff;

   obst_type                  mem [MAX_OBSTACLES];
   obst_type                  rd_ff;
   logic                      wr_en;
   obst_type                  wr_data;

   logic                      rsp_valid_ff;
   logic                      rsp_kind_ff, rsp_intersects_ff, rsp_any_ff, rsp_last_ff;
   logic [1:0]                rsp_status_ff;
   logic [OBS_IDX_W-1:0]      rsp_index_ff;
   logic signed [CLR_W-1:0]   rsp_clr_ff;

   logic                      req_take;
   logic                      out_free;
   logic                      out_load;
   logic                      in_bounds;
   logic signed [COORD_W:0]   dx, dy;
   logic [ABS_W-1:0]          ax, ay, mul_a;
   logic [SQ_W-1:0]           mul_p;
   logic                      root_start, root_done;
   logic [ROOT_W-1:0]         root;
   logic signed [CLR_W-1:0]   clr;
   logic                      hit;
   logic                      is_last;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign in_bounds = (req_center_x >= min_x_ff) && (req_center_x <= max_x_ff) &&
                      (req_center_y >= min_y_ff) && (req_center_y <= max_y_ff);

   // Shared squaring multiplier: x in one step, y in the next
   assign dx    = (COORD_W+1)'(rd_ff.x) - (COORD_W+1)'(qx_ff);
   assign dy    = (COORD_W+1)'(rd_ff.y) - (COORD_W+1)'(qy_ff);
   assign ax    = dx[COORD_W] ? ABS_W'(-dx) : ABS_W'(dx);
   assign ay    = dy[COORD_W] ? ABS_W'(-dy) : ABS_W'(dy);
   assign mul_a = (state_ff == S_SQX) ? ax : ay;
   assign mul_p = mul_a * mul_a;

   assign root_start = (state_ff == S_START);

   coc_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .value (sum_ff),
      .done  (root_done),
      .root  (root)
   );

   assign clr = CLR_W'(root) - CLR_W'(rd_ff.r) - CLR_W'(qr_ff);
   assign hit = clr[CLR_W-1];
   assign is_last = (CNT_W'(idx_ff) + 1'b1) == count_ff;

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      kind_in   = kind_ff;
      status_in = status_ff;
      any_in    = any_ff;
      wr_en     = 1'b0;
      wr_data   = '{x: req_center_x, y: req_center_y, r: req_circle_radius};
      out_load  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               idx_in = '0;
               any_in = 1'b0;
               if (req_op == OP_ADD) begin
                  kind_in  = KIND_ADD;
                  state_in = S_EMIT;
                  if (!in_bounds) begin
                     status_in = ST_BOUND;
                  end else if (count_ff >= CNT_W'(MAX_OBSTACLES)) begin
                     status_in = ST_FULL;
                  end else begin
                     status_in = ST_OK;
                     wr_en     = 1'b1;
                     idx_in    = IDX_W'(count_ff);
                     count_in  = count_ff + 1'b1;
                  end
               end else begin
                  kind_in = KIND_QUERY;
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_EMIT;
                  end else begin
                     status_in = ST_OK;
                     state_in  = S_READ;
                  end
               end
            end
         end
         S_READ:  state_in = S_SQX;
         S_SQX:   state_in = S_SQY;
         S_SQY:   state_in = S_START;
         S_START: state_in = S_ROOT;
         S_ROOT: begin
            if (root_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               if (kind_ff == KIND_QUERY && status_ff == ST_OK) begin
                  any_in = any_ff | hit;
                  if (is_last) begin
                     state_in = S_IDLE;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = S_READ;
                  end
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers and world bounds
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         min_x_ff <= {1'b1, {(COORD_W-1){1'b0}}};
         max_x_ff <= {1'b0, {(COORD_W-1){1'b1}}};
         min_y_ff <= {1'b1, {(COORD_W-1){1'b0}}};
         max_y_ff <= {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_we) begin
            unique case (csr_idx_type'(csr_index))
               CSR_MIN_X: min_x_ff <= csr_wdata;
               CSR_MAX_X: max_x_ff <= csr_wdata;
               CSR_MIN_Y: min_y_ff <= csr_wdata;
               CSR_MAX_Y: max_y_ff <= csr_wdata;
               default:   min_x_ff <= min_x_ff;
            endcase
         end
      end
   end

   // Item context and arithmetic holding registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      kind_ff   <= kind_in;
      status_ff <= status_in;
      any_ff    <= any_in;
      if (req_take) begin
         qx_ff <= req_center_x;
         qy_ff <= req_center_y;
         qr_ff <= req_circle_radius;
      end
      if (state_ff == S_SQX) begin
         sq_ff <= mul_p;
      end
      if (state_ff == S_SQY) begin
         sum_ff <= SUM_W'(sq_ff) + SUM_W'(mul_p);
      end
   end

   // Obstacle table: one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IDX_W-1:0]] <= wr_data;
      end
      if (state_ff == S_READ) begin
         rd_ff <= mem[idx_ff];
      end
   end

   // Output register: load on emit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_kind_ff   <= kind_ff;
         rsp_status_ff <= status_ff;
         if (kind_ff == KIND_QUERY && status_ff == ST_OK) begin
            rsp_index_ff      <= OBS_IDX_W'(idx_ff);
            rsp_clr_ff        <= clr;
            rsp_intersects_ff <= hit;
            rsp_any_ff        <= any_ff | hit;
            rsp_last_ff       <= is_last;
         end else begin
            rsp_index_ff      <= (status_ff == ST_OK) ? OBS_IDX_W'(idx_ff) : '0;
            rsp_clr_ff        <= '0;
            rsp_intersects_ff <= 1'b0;
            rsp_any_ff        <= 1'b0;
            rsp_last_ff       <= 1'b1;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_obstacle_index = rsp_index_ff;
   assign rsp_clearance      = rsp_clr_ff;
   assign rsp_intersects     = rsp_intersects_ff;
   assign rsp_any_hit        = rsp_any_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

// File: test/tb_circle_obstacle_clearance_top.sv
// Testbench for the circle obstacle clearance block: random and directed adds and queries
module tb_circle_obstacle_clearance_top
   import coc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS   = DEF_MAX_OBSTACLES;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE      = 60;

   typedef struct {
      logic                      op;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic [RAD_W-1:0]          rad;
   } circle_item_type;

   typedef struct {
      logic                    kind;
      status_type              status;
      logic [OBS_IDX_W-1:0]    idx;
      logic signed [CLR_W-1:0] clr;
      logic                    hit;
      logic                    any;
      logic                    last;
   } clearance_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = 1'b0;
   logic signed [COORD_W-1:0] req_center_x = '0;
   logic signed [COORD_W-1:0] req_center_y = '0;
   logic [RAD_W-1:0] req_circle_radius = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_kind;
   logic [1:0] rsp_status;
   logic [OBS_IDX_W-1:0] rsp_obstacle_index;
   logic signed [CLR_W-1:0] rsp_clearance;
   logic rsp_intersects;
   logic rsp_any_hit;
   logic rsp_last;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COORD_W-1:0] csr_wdata = '0;

   circle_item_type      pending_items[$];
   clearance_result_type expected_results[$];
   circle_item_type      cur_item;
   int errors = 0;
   int items_taken = 0;
   int results_seen = 0;
   int cycles = 0;

   // tb copy of the bounds and the obstacle table
   logic signed [COORD_W-1:0] bound_min_x, bound_max_x, bound_min_y, bound_max_y;
   logic signed [COORD_W-1:0] table_x[NUM_SLOTS];
   logic signed [COORD_W-1:0] table_y[NUM_SLOTS];
   logic [RAD_W-1:0]          table_r[NUM_SLOTS];
   int table_count = 0;

   circle_obstacle_clearance_top DUT (.*);

   initial forever #5 clock = ~clock;

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned res, bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > v) bits >>= 2;
      while (bits != 0) begin
         if (v >= res + bits) begin
            v = v - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits >>= 2;
      end
      return res;
   endfunction

   // Update the table and queue the results one accepted item causes
   task automatic predict_clearance(circle_item_type it);
      clearance_result_type r;
      longint dx, dy, d, c;
      logic any_hit;
      r = '{KIND_ADD, ST_OK, '0, '0, 1'b0, 1'b0, 1'b1};
      if (it.op == OP_ADD) begin
         if (it.cx < bound_min_x || it.cx > bound_max_x ||
             it.cy < bound_min_y || it.cy > bound_max_y) begin
            r.status = ST_BOUND;
         end else if (table_count >= NUM_SLOTS) begin
            r.status = ST_FULL;
         end else begin
            table_x[table_count] = it.cx;
            table_y[table_count] = it.cy;
            table_r[table_count] = it.rad;
            r.idx = table_count[OBS_IDX_W-1:0];
            table_count++;
         end
         expected_results.push_back(r);
      end else if (table_count == 0) begin
         r.kind = KIND_QUERY;
         r.status = ST_EMPTY;
         expected_results.push_back(r);
      end else begin
         any_hit = 1'b0;
         for (int i = 0; i < table_count; i++) begin
            dx = longint'(table_x[i]) - longint'(it.cx);
            dy = longint'(table_y[i]) - longint'(it.cy);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            d = longint'(floor_root(dx * dx + dy * dy));
            c = d - longint'(table_r[i]) - longint'(it.rad);
            if (c > 67108863) c = 67108863;
            if (c < -67108864) c = -67108864;
            r.kind = KIND_QUERY;
            r.status = ST_OK;
            r.idx = i[OBS_IDX_W-1:0];
            r.clr = c[CLR_W-1:0];
            r.hit = (c < 0);
            any_hit = any_hit | r.hit;
            r.any = any_hit;
            r.last = (i + 1 == table_count);
            expected_results.push_back(r);
         end
      end
   endtask

   // Driver: present items from the pending queue, idle at random
   always @(posedge clock) begin
      logic calm;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else if (!reset) begin
         calm = (items_taken >= 40 && items_taken < 75);
         if (req_valid && !req_stall) begin
            predict_clearance(cur_item);
            items_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 32)) begin
               cur_item = pending_items.pop_front();
               req_valid <= 1'b1;
               req_op <= cur_item.op;
               req_center_x <= cur_item.cx;
               req_center_y <= cur_item.cy;
               req_circle_radius <= cur_item.rad;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall at random and check each accepted result
   always @(posedge clock) begin
      clearance_result_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $error("result with nothing expected: index %0d", rsp_obstacle_index);
               errors++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_kind !== e.kind) begin
                  $error("kind: expected %0d actual %0d", e.kind, rsp_kind); errors++;
               end
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d actual %0d", e.status, rsp_status); errors++;
               end
               if (rsp_obstacle_index !== e.idx) begin
                  $error("obstacle_index: expected %0d actual %0d", e.idx,
                         rsp_obstacle_index);
                  errors++;
               end
               if (rsp_clearance !== e.clr) begin
                  $error("clearance: expected %0d actual %0d", e.clr, rsp_clearance);
                  errors++;
               end
               if (rsp_intersects !== e.hit) begin
                  $error("intersects: expected %0d actual %0d", e.hit, rsp_intersects);
                  errors++;
               end
               if (rsp_any_hit !== e.any) begin
                  $error("any_hit: expected %0d actual %0d", e.any, rsp_any_hit);
                  errors++;
               end
               if (rsp_last !== e.last) begin
                  $error("last: expected %0d actual %0d", e.last, rsp_last); errors++;
               end
            end
         end
         rsp_stall <= (results_seen >= 300 && results_seen < 600) ? 1'b0
                      : ($urandom_range(0, 99) < 32);
      end
   end

   task automatic add_item(logic op, int x, int y, int r);
      circle_item_type it;
      it.op = op;
      it.cx = x[COORD_W-1:0];
      it.cy = y[COORD_W-1:0];
      it.rad = r[RAD_W-1:0];
      pending_items.push_back(it);
   endtask

   // Hold until every item is taken and answered, then let the block drain
   task automatic wait_idle();
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_bound(csr_idx_type idx, int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[COORD_W-1:0];
      case (idx)
         CSR_MIN_X: bound_min_x = value[COORD_W-1:0];
         CSR_MAX_X: bound_max_x = value[COORD_W-1:0];
         CSR_MIN_Y: bound_min_y = value[COORD_W-1:0];
         default:   bound_max_y = value[COORD_W-1:0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_bounds(int lx, int hx, int ly, int hy);
      write_bound(CSR_MIN_X, lx);
      write_bound(CSR_MAX_X, hx);
      write_bound(CSR_MIN_Y, ly);
      write_bound(CSR_MAX_Y, hy);
   endtask

   function automatic int pick(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   initial begin
      int lx, hx, ly, hy;
      bound_min_x = -24'sd8388608;
      bound_max_x = 24'sd8388607;
      bound_min_y = -24'sd8388608;
      bound_max_y = 24'sd8388607;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset bounds: empty query, corner obstacles, extreme queries
      add_item(OP_QUERY, 0, 0, 0);
      add_item(OP_ADD, -8388608, -8388608, 0);
      add_item(OP_ADD, 8388607, 8388607, 8388607);
      add_item(OP_QUERY, 8388607, 8388607, 8388607);
      add_item(OP_QUERY, -8388608, 8388607, 0);
      add_item(OP_QUERY, -8388608, -8388608, 1);
      wait_idle();

      // Narrow bounds: refuse outside centers, accept edge centers
      set_bounds(-1000, 1000, -500, 500);
      add_item(OP_ADD, 1001, 0, 10);
      add_item(OP_ADD, -1001, 0, 10);
      add_item(OP_ADD, 0, 501, 10);
      add_item(OP_ADD, 0, -501, 10);
      add_item(OP_ADD, 1000, 500, 300);
      add_item(OP_ADD, -1000, -500, 0);
      add_item(OP_ADD, 0, 0, 256);
      add_item(OP_QUERY, 0, 0, 0);
      add_item(OP_QUERY, 300, 400, 244);
      wait_idle();

      // Inverted bounds refuse every add
      set_bounds(100, -100, 50, -50);
      add_item(OP_ADD, 0, 0, 1);
      add_item(OP_ADD, 100, 50, 1);
      add_item(OP_QUERY, 100, 50, 8388607);
      wait_idle();

      // Random bounds with mostly in-range adds
      lx = -pick(0, 4000000); hx = pick(0, 4000000);
      ly = -pick(0, 4000000); hy = pick(0, 4000000);
      set_bounds(lx, hx, ly, hy);
      for (int n = 0; n < 25; n++) begin
         if ($urandom_range(0, 99) < 35)
            add_item(OP_QUERY, int'($urandom), int'($urandom), int'($urandom));
         else if ($urandom_range(0, 99) < 75)
            add_item(OP_ADD, pick(lx, hx), pick(ly, hy), pick(0, 20000));
         else
            add_item(OP_ADD, int'($urandom), int'($urandom), int'($urandom));
      end
      wait_idle();

      // Full range bounds: fill the table, then full refusals and full queries
      set_bounds(-8388608, 8388607, -8388608, 8388607);
      for (int n = 0; n < 67; n++) begin
         if ($urandom_range(0, 99) < 45)
            add_item(OP_QUERY, int'($urandom), int'($urandom), pick(0, 8388607));
         else
            add_item(OP_ADD, int'($urandom), int'($urandom),
                     ($urandom_range(0, 3) == 0) ? pick(0, 8388607) : pick(0, 50000));
      end
      wait_idle();
      repeat (SETTLE) @(posedge clock);

      if (errors == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
